@@ hw/rtl/lbprm_pkg.sv @@
`timescale 1ns / 1ps

package lbprm_pkg;

    // Default width of the pattern code that is rotated
    localparam int CODE_BITS_DEF = 8;

    // Item field widths
    localparam int CODE_W  = 8;
    localparam int BIN_W   = 8;
    localparam int COUNT_W = 24;
    localparam int TOTAL_W = 32;

    // Histogram geometry
    localparam int HIST_DEPTH = 1 << BIN_W;

    // Request codes
    localparam logic REQ_ADD  = 1'b0;
    localparam logic REQ_READ = 1'b1;

endpackage

@@ hw/rtl/lbprm_rotmin.sv @@
`timescale 1ns / 1ps

module lbprm_rotmin #(
    parameter int CODE_BITS = lbprm_pkg::CODE_BITS_DEF
) (
    input  logic [lbprm_pkg::CODE_W-1:0] i_code,
    output logic [lbprm_pkg::BIN_W-1:0]  o_bin
);
    import lbprm_pkg::*;

    localparam int LEVELS = $clog2(CODE_BITS);
    localparam int N      = 1 << LEVELS;

    logic [CODE_BITS-1:0] w_v;
    logic [CODE_BITS-1:0] w_tree [LEVELS+1][N];

    // Code brought to CODE_BITS bits: truncated or zero-extended
    generate
        if (CODE_BITS > CODE_W) begin : g_ext
            assign w_v = {{(CODE_BITS-CODE_W){1'b0}}, i_code};
        end else begin : g_trunc
            assign w_v = i_code[CODE_BITS-1:0];
        end
    endgenerate

    // Leaves: every circular rotation, unused leaves padded with all ones
    generate
        for (genvar j = 0; j < N; j++) begin : g_rot
            if (j == 0) begin : g_id
                assign w_tree[0][j] = w_v;
            end else if (j < CODE_BITS) begin : g_r
                assign w_tree[0][j] = (w_v << j) | (w_v >> (CODE_BITS - j));
            end else begin : g_pad
                assign w_tree[0][j] = '1;
            end
        end
    endgenerate

    // Minimum tree over the rotations
    generate
        for (genvar l = 0; l < LEVELS; l++) begin : g_lvl
            for (genvar k = 0; k < N; k++) begin : g_node
                if (k < (N >> (l + 1))) begin : g_min
                    assign w_tree[l+1][k] = (w_tree[l][2*k+1] < w_tree[l][2*k]) ?
                                            w_tree[l][2*k+1] : w_tree[l][2*k];
                end else begin : g_idle
                    assign w_tree[l+1][k] = '1;
                end
            end
        end
    endgenerate

    // Bin index: the minimum never exceeds the code, so it fits the histogram
    generate
        if (CODE_BITS >= BIN_W) begin : g_bin_trunc
            assign o_bin = w_tree[LEVELS][0][BIN_W-1:0];
        end else begin : g_bin_ext
            assign o_bin = {{(BIN_W-CODE_BITS){1'b0}}, w_tree[LEVELS][0]};
        end
    endgenerate

endmodule

@@ hw/rtl/rotation_min_lbp_histogram_remap.sv @@
`timescale 1ns / 1ps
// Rotation-invariant LBP histogram remap.
// Input channel (i_valid / o_stall): an item carries i_req_type, i_code and
// i_count. An add item maps i_code to the smallest circular rotation within
// CODE_BITS bits and adds i_count to that bin, saturating at all ones. A read
// item returns the bin named by i_code and clears it.
// Output channel (o_valid / i_stall): one item per input item with o_bin and
// o_total (the new total on add, the old total on read).
// Timing: the rotation minimum and the histogram read happen in the accept
// cycle; the write-back state then modifies and writes the bin back and loads
// the output register, waiting while it holds a stalled item. No new item is
// taken until that write-back, due to the read-modify-write of the single-port histogram.
// Reset clears the per-bin valid flags at once, so every bin reads as zero
// with no clearing pass. While the receiver stalls a finished item waits in
// the output register; the next item is still accepted and held at its
// write-back until the output register frees.
module rotation_min_lbp_histogram_remap #(
    parameter int CODE_BITS = lbprm_pkg::CODE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_req_type,
    input  logic [lbprm_pkg::CODE_W-1:0]     i_code,
    input  logic [lbprm_pkg::COUNT_W-1:0]    i_count,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [lbprm_pkg::BIN_W-1:0]      o_bin,
    output logic [lbprm_pkg::TOTAL_W-1:0]    o_total
);
    import lbprm_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WB   = 1'b1;

    logic                 r_state, n_state;
    logic                 r_req;
    logic [BIN_W-1:0]     r_bin;
    logic [COUNT_W-1:0]   r_count;
    logic [TOTAL_W-1:0]   r_rdata;
    logic                 r_rdvld;
    logic [HIST_DEPTH-1:0] r_vld;
    logic                 r_out_valid;
    logic [BIN_W-1:0]     r_out_bin;
    logic [TOTAL_W-1:0]   r_out_total;

    logic [TOTAL_W-1:0]   mem [HIST_DEPTH];

    logic [BIN_W-1:0]     w_rot_bin;
    logic [BIN_W-1:0]     w_addr;
    logic                 w_accept;
    logic                 w_wb_go;
    logic [TOTAL_W-1:0]   w_cur;
    logic [TOTAL_W:0]     w_sum;
    logic [TOTAL_W-1:0]   w_sat;
    logic [TOTAL_W-1:0]   w_wdata;
    logic [TOTAL_W-1:0]   w_result;

    lbprm_rotmin #(
        .CODE_BITS (CODE_BITS)
    ) u_rotmin (
        .i_code (i_code),
        .o_bin  (w_rot_bin)
    );

    // Handshake
    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_wb_go  = (r_state == ST_WB) && (!r_out_valid || !i_stall);
    assign w_addr   = (i_req_type == REQ_ADD) ? w_rot_bin : i_code;

    // Modify: saturating add, or clear on read
    assign w_cur    = r_rdvld ? r_rdata : '0;
    assign w_sum    = {1'b0, w_cur} + {{(TOTAL_W+1-COUNT_W){1'b0}}, r_count};
    assign w_sat    = w_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : w_sum[TOTAL_W-1:0];
    assign w_wdata  = (r_req == REQ_ADD) ? w_sat : '0;
    assign w_result = (r_req == REQ_ADD) ? w_sat : w_cur;

    // State sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_WB;
            end
            ST_WB: begin
                if (w_wb_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Histogram memory: read at accept, write back at modify
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rdata <= mem[w_addr];
        end
        if (w_wb_go) begin
            mem[r_bin] <= w_wdata;
        end
    end

    // Per-bin valid flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_wb_go) begin
            r_vld[r_bin] <= 1'b1;
        end
    end

    // Captured item
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req   <= i_req_type;
            r_bin   <= w_addr;
            r_count <= i_count;
            r_rdvld <= r_vld[w_addr];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_wb_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wb_go) begin
            r_out_bin   <= r_bin;
            r_out_total <= w_result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_bin   = r_out_bin;
    assign o_total = r_out_total;

    // Checks
    a_accept_to_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_WB))
        else $error("accepted item did not move to write-back");

    a_out_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == ST_WB))
        else $error("output item appeared without a write-back");

    a_add_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wb_go && r_req == REQ_ADD) |=>
            (o_total >= {{(TOTAL_W-COUNT_W){1'b0}}, $past(r_count)}))
        else $error("add total below its count");

endmodule

@@ verif/rotation_min_lbp_histogram_remap_test.sv @@
`timescale 1ns / 1ps

module rotation_min_lbp_histogram_remap_test;

    import lbprm_pkg::*;

    localparam int ROT_W       = CODE_BITS_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 8;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_idx;
        logic [TOTAL_W-1:0] total;
    } t_bin_total;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_EVERY_THIRD
    } t_stall_mode;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic                 i_req_type;
    logic [CODE_W-1:0]    i_code;
    logic [COUNT_W-1:0]   i_count;
    logic                 o_valid;
    logic                 i_stall;
    logic [BIN_W-1:0]     o_bin;
    logic [TOTAL_W-1:0]   o_total;

    // Local copy of the histogram and the totals still owed by the block
    logic [TOTAL_W-1:0]   hist_model [HIST_DEPTH];
    t_bin_total           owed_totals [$];
    int                   mismatches;

    // Sender burst control, receiver hold-off request
    int                   burst_left;
    int                   gap_max;
    bit                   hold_off_req;

    rotation_min_lbp_histogram_remap #(
        .CODE_BITS(ROT_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_code     (i_code),
        .i_count    (i_count),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_bin      (o_bin),
        .o_total    (o_total)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Smallest circular rotation of the pattern within ROT_W bits
    function automatic logic [BIN_W-1:0] min_rotation(input logic [CODE_W-1:0] pattern);
        logic [31:0] mask;
        logic [31:0] v;
        logic [31:0] best;
        logic [31:0] r;
        mask = (32'd1 << ROT_W) - 32'd1;
        v    = {{(32-CODE_W){1'b0}}, pattern} & mask;
        best = v;
        for (int s = 1; s < ROT_W; s++) begin
            r = ((v << s) | (v >> (ROT_W - s))) & mask;
            if (r < best) begin
                best = r;
            end
        end
        return best[BIN_W-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [TOTAL_W-1:0] got,
                                   input logic [TOTAL_W-1:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    // Predict on each accepted input item, then check each accepted result
    always @(posedge i_clk) begin : track_items
        logic [BIN_W-1:0]   idx;
        logic [TOTAL_W:0]   sum;
        t_bin_total         want;
        if (i_rst_n && i_valid && !o_stall) begin
            if (i_req_type == REQ_ADD) begin
                idx = min_rotation(i_code);
                sum = {1'b0, hist_model[idx]} + {{(TOTAL_W+1-COUNT_W){1'b0}}, i_count};
                hist_model[idx] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
                want.bin_idx = idx;
                want.total   = hist_model[idx];
            end else begin
                idx = i_code[BIN_W-1:0];
                want.bin_idx = idx;
                want.total   = hist_model[idx];
                hist_model[idx] = '0;
            end
            owed_totals.push_back(want);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (owed_totals.size() == 0) begin
                report_mismatch("unexpected result", {{(TOTAL_W-BIN_W){1'b0}}, o_bin}, '0);
            end else begin
                want = owed_totals.pop_front();
                if (o_bin !== want.bin_idx) begin
                    report_mismatch("bin", {{(TOTAL_W-BIN_W){1'b0}}, o_bin},
                                    {{(TOTAL_W-BIN_W){1'b0}}, want.bin_idx});
                end
                if (o_total !== want.total) begin
                    report_mismatch("total", o_total, want.total);
                end
            end
        end
    end

    // Receiver stall pattern, with an occasional long hold-off on request
    initial begin : rx_stall_gen
        t_stall_mode mode;
        int          left;
        i_stall = 1'b0;
        mode    = STALL_NONE;
        left    = 0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_stall = 1'b1;
                for (int held = 1; held < HOLD_CYCLES; held++) begin
                    @(negedge i_clk);
                end
                hold_off_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_stall_mode'($urandom_range(0, 3));
                    left = $urandom_range(16, 96);
                end
                left--;
                case (mode)
                    STALL_NONE:        i_stall = 1'b0;
                    STALL_LIGHT:       i_stall = ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:       i_stall = ($urandom_range(0, 9) < 7);
                    STALL_EVERY_THIRD: i_stall = (left % 3 == 0);
                    default:           i_stall = 1'b0;
                endcase
            end
        end
    end

    // Watchdog: too long with no item moving on either side
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Offer one item, idling between bursts, and wait until it is taken
    task automatic send_item(input logic req, input logic [CODE_W-1:0] pattern,
                             input logic [COUNT_W-1:0] tally);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid = 1'b0;
            end
            burst_left = $urandom_range(1, 12);
        end
        @(negedge i_clk);
        i_valid    = 1'b1;
        i_req_type = req;
        i_code     = pattern;
        i_count    = tally;
        do @(posedge i_clk); while (o_stall);
        burst_left--;
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return '1;
            2:       return COUNT_W'($urandom_range(1, 15));
            default: return COUNT_W'($urandom);
        endcase
    endfunction

    // Extremes of the fields and each special case
    task automatic test_directed();
        send_item(REQ_ADD,  8'h00, '0);
        send_item(REQ_ADD,  8'h00, '1);
        send_item(REQ_ADD,  8'hFF, '1);
        send_item(REQ_ADD,  8'h80, 24'd1);
        send_item(REQ_ADD,  8'h01, 24'd2);
        send_item(REQ_ADD,  8'hAA, 24'h123456);
        send_item(REQ_ADD,  8'h55, 24'hABCDEF);
        send_item(REQ_ADD,  8'h96, 24'd5);
        send_item(REQ_ADD,  8'h7F, 24'h800000);
        send_item(REQ_ADD,  8'hFE, 24'd1);
        // zero count on a populated bin
        send_item(REQ_ADD,  8'h01, '0);
        // count is ignored on read; second read sees the cleared bin
        send_item(REQ_READ, 8'h55, '1);
        send_item(REQ_READ, 8'h55, '0);
        // bin that no add can reach
        send_item(REQ_READ, 8'h80, 24'h5A5A5A);
        send_item(REQ_READ, 8'h00, '0);
        send_item(REQ_READ, 8'hFF, '0);
        send_item(REQ_READ, 8'h7F, '0);
        send_item(REQ_ADD,  8'hC3, 24'd1);
        send_item(REQ_ADD,  8'h3C, '1);
        send_item(REQ_READ, 8'h0F, '0);
        send_item(REQ_ADD,  8'h11, 24'd7);
        send_item(REQ_READ, 8'h01, '0);
    endtask

    // Drive one bin past the top of its range through single-bit codes
    task automatic test_saturation();
        send_item(REQ_READ, 8'h01, '0);
        repeat (262) begin
            send_item(REQ_ADD, 8'h01 << $urandom_range(0, CODE_W - 1),
                      COUNT_W'($urandom_range(0, 1) ? 24'hFFFFFF : 24'hFFFFF0));
        end
        send_item(REQ_ADD,  8'h08, '0);
        send_item(REQ_READ, 8'h01, '0);
        send_item(REQ_ADD,  8'h02, 24'd3);
    endtask

    // Long receiver hold-off while the sender keeps offering items
    task automatic test_backpressure();
        gap_max      = 0;
        hold_off_req = 1'b1;
        repeat (40) begin
            send_item(($urandom_range(0, 3) == 0) ? REQ_READ : REQ_ADD,
                      CODE_W'($urandom), pick_count());
        end
        gap_max = 4;
    endtask

    // Mostly adds, some reads aimed at bins that have been hit
    task automatic test_random();
        logic [BIN_W-1:0] hot_bins [$];
        logic [CODE_W-1:0] pattern;
        for (int n = 0; n < 1420; n++) begin
            if (n % 150 == 0) begin
                case ($urandom_range(0, 2))
                    0:       gap_max = 0;
                    1:       gap_max = 3;
                    default: gap_max = 10;
                endcase
            end
            if ($urandom_range(0, 4) != 0) begin
                pattern = CODE_W'($urandom);
                hot_bins.push_back(min_rotation(pattern));
                if (hot_bins.size() > 8) begin
                    void'(hot_bins.pop_front());
                end
                send_item(REQ_ADD, pattern, pick_count());
            end else if ($urandom_range(0, 1) && hot_bins.size() != 0) begin
                send_item(REQ_READ, hot_bins[$urandom_range(0, hot_bins.size() - 1)],
                          COUNT_W'($urandom));
            end else begin
                send_item(REQ_READ, CODE_W'($urandom), COUNT_W'($urandom));
            end
        end
    endtask

    // Main sequence
    initial begin : run_tests
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_req_type   = REQ_ADD;
        i_code       = '0;
        i_count      = '0;
        mismatches   = 0;
        burst_left   = 0;
        gap_max      = 4;
        hold_off_req = 1'b0;
        foreach (hist_model[k]) hist_model[k] = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_saturation();
        test_backpressure();
        test_random();

        @(negedge i_clk);
        i_valid = 1'b0;
        while (owed_totals.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
